// ===== rtl/nca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// Shared constants, codes and types of the nearest-centroid assignment block.
// ----------------------------------------------------------------------------
package nca_pkg;

   localparam int MAX_CENTROIDS = 64;
   localparam int MAX_DIMS      = 64;
   localparam int MAX_POINTS    = 256;

   localparam int CENT_W   = $clog2(MAX_CENTROIDS);
   localparam int DIM_W    = $clog2(MAX_DIMS);
   localparam int PT_W     = $clog2(MAX_POINTS);
   localparam int CADDR_W  = CENT_W + DIM_W;
   localparam int PADDR_W  = PT_W + DIM_W;

   localparam int OP_W     = 2;
   localparam int ENTRY_W  = 8;
   localparam int DIMIN_W  = 6;
   localparam int COORD_W  = 16;
   localparam int BEST_W   = 6;
   localparam int CFG_W    = 7;
   localparam int CSR_IDX_W = 1;

   localparam int MAG_W    = COORD_W;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int ACC_W    = 40;

   localparam logic [OP_W-1:0] OP_LOAD_CENT  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_POINT = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTROIDS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS      = 1'b1;

   // tag that travels with each coordinate pair through the distance pipe
   typedef struct packed {
      logic              valid;
      logic              last_dim;
      logic              first_cent;
      logic              last_cent;
      logic [CENT_W-1:0] cent;
   } nca_tag_type;

   typedef struct packed {
      logic              done;
      logic [CENT_W-1:0] best;
   } nca_result_type;

endpackage

// ===== rtl/nca_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nca_req_if;
   import nca_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [ENTRY_W-1:0]        entry_index;
   logic [DIMIN_W-1:0]        dim_index;
   logic signed [COORD_W-1:0] coord_value;

   modport source (output valid, op, entry_index, dim_index, coord_value, input ready);
   modport sink   (input valid, op, entry_index, dim_index, coord_value, output ready);
endinterface

interface nca_rsp_if;
   import nca_pkg::*;
   logic              valid;
   logic              ready;
   logic [BEST_W-1:0] best_centroid;

   modport source (output valid, best_centroid, input ready);
   modport sink   (input valid, best_centroid, output ready);
endinterface

interface nca_csr_if;
   import nca_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/nearest_centroid_assign.sv =====
`timescale 1ns / 1ps
// A query steps through every centroid and dimension of the set counts, with one
// multiply-accumulate per cycle through the shared distance unit.
// Throughput: loads one item per cycle; one query at a time, not ready while it runs.
// Reset: synchronous, active high; sets both counts to 1, clears control state.
// Centroid and point stores are undefined until written.
// ----------------------------------------------------------------------------
// nearest_centroid_assign
// Nearest-centroid lookup by exact squared L2 distance over stored vectors.
// ----------------------------------------------------------------------------
module nearest_centroid_assign
   import nca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   nca_req_if.sink     req_ch,
   nca_rsp_if.source   rsp_ch,
   nca_csr_if.sink     csr_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_HOLD
   } state_type;

   state_type          state_in, state_ff;
   logic [CFG_W-1:0]   cent_cfg_ff, dims_cfg_ff;
   logic [CENT_W-1:0]  last_cent_in, last_cent_ff;
   logic [DIM_W-1:0]   last_dim_in, last_dim_ff;
   logic [CENT_W-1:0]  cent_in, cent_ff;
   logic [DIM_W-1:0]   dim_in, dim_ff;
   logic [PT_W-1:0]    point_in, point_ff;
   nca_tag_type        tag_in, tag_ff;
   logic               rsp_valid_in, rsp_valid_ff;
   logic [BEST_W-1:0]  rsp_best_in, rsp_best_ff;
   logic [CENT_W-1:0]  hold_best_in, hold_best_ff;

   logic               accept;
   logic               cent_we, point_we;
   logic               dim_ok;
   logic signed [COORD_W-1:0] pt_q, ct_q;
   nca_result_type     result;

   // register port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cent_cfg_ff <= CFG_W'(1);
         dims_cfg_ff <= CFG_W'(1);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_CENTROIDS: cent_cfg_ff <= csr_ch.data;
            CSR_DIMS:      dims_cfg_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // loads
   assign accept   = req_ch.valid && req_ch.ready;
   assign dim_ok   = (DIMIN_W+1)'(req_ch.dim_index) < (DIMIN_W+1)'(MAX_DIMS);
   assign cent_we  = accept && (req_ch.op == OP_LOAD_CENT) && dim_ok &&
                     ((ENTRY_W+1)'(req_ch.entry_index) < (ENTRY_W+1)'(MAX_CENTROIDS));
   assign point_we = accept && (req_ch.op == OP_LOAD_POINT) && dim_ok &&
                     ((ENTRY_W+1)'(req_ch.entry_index) < (ENTRY_W+1)'(MAX_POINTS));

   nca_ram #(.DEPTH(MAX_CENTROIDS * MAX_DIMS), .WIDTH(COORD_W)) u_cent_ram (
      .clock (clock),
      .we    (cent_we),
      .waddr ({req_ch.entry_index[CENT_W-1:0], req_ch.dim_index[DIM_W-1:0]}),
      .wdata (req_ch.coord_value),
      .raddr ({cent_ff, dim_ff}),
      .rdata (ct_q)
   );

   nca_ram #(.DEPTH(MAX_POINTS * MAX_DIMS), .WIDTH(COORD_W)) u_point_ram (
      .clock (clock),
      .we    (point_we),
      .waddr ({req_ch.entry_index[PT_W-1:0], req_ch.dim_index[DIM_W-1:0]}),
      .wdata (req_ch.coord_value),
      .raddr ({point_ff, dim_ff}),
      .rdata (pt_q)
   );

   nca_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .tag      (tag_ff),
      .pt_coord (pt_q),
      .ct_coord (ct_q),
      .result   (result)
   );

   // counts saturated to 1 .. MAX, held as last index
   always_comb begin
      if (cent_cfg_ff == '0) begin
         last_cent_in = '0;
      end else if (cent_cfg_ff > CFG_W'(MAX_CENTROIDS)) begin
         last_cent_in = CENT_W'(MAX_CENTROIDS - 1);
      end else begin
         last_cent_in = CENT_W'(cent_cfg_ff - CFG_W'(1));
      end
      if (dims_cfg_ff == '0) begin
         last_dim_in = '0;
      end else if (dims_cfg_ff > CFG_W'(MAX_DIMS)) begin
         last_dim_in = DIM_W'(MAX_DIMS - 1);
      end else begin
         last_dim_in = DIM_W'(dims_cfg_ff - CFG_W'(1));
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cent_in      = cent_ff;
      dim_in       = dim_ff;
      point_in     = point_ff;
      tag_in       = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_best_in  = rsp_best_ff;
      hold_best_in = hold_best_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_ch.op == OP_QUERY) &&
                ((ENTRY_W+1)'(req_ch.entry_index) < (ENTRY_W+1)'(MAX_POINTS))) begin
               point_in = req_ch.entry_index[PT_W-1:0];
               cent_in  = '0;
               dim_in   = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            tag_in.valid      = 1'b1;
            tag_in.last_dim   = (dim_ff == last_dim_ff);
            tag_in.first_cent = (cent_ff == '0);
            tag_in.last_cent  = (cent_ff == last_cent_ff);
            tag_in.cent       = cent_ff;
            if (dim_ff == last_dim_ff) begin
               dim_in  = '0;
               cent_in = cent_ff + CENT_W'(1);
               if (cent_ff == last_cent_ff) begin
                  state_in = ST_WAIT;
               end
            end else begin
               dim_in = dim_ff + DIM_W'(1);
            end
         end
         ST_WAIT: begin
            if (result.done) begin
               hold_best_in = result.best;
               state_in     = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = BEST_W'(hold_best_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cent_ff      <= cent_in;
      dim_ff       <= dim_in;
      point_ff     <= point_in;
      rsp_best_ff  <= rsp_best_in;
      hold_best_ff <= hold_best_in;
      last_cent_ff <= (state_ff == ST_IDLE) ? last_cent_in : last_cent_ff;
      last_dim_ff  <= (state_ff == ST_IDLE) ? last_dim_in : last_dim_ff;
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.best_centroid = rsp_best_ff;

endmodule

// ===== rtl/nca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nca_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/nca_dist_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_dist_unit
// Shared squared-difference accumulator with running minimum over centroids.
// ----------------------------------------------------------------------------
module nca_dist_unit
   import nca_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  nca_tag_type               tag,
   input  logic signed [COORD_W-1:0] pt_coord,
   input  logic signed [COORD_W-1:0] ct_coord,
   output nca_result_type            result
);

   logic signed [COORD_W:0] diff;
   logic [MAG_W-1:0]        mag_in, mag_ff;
   logic [SQ_W-1:0]         sq_in, sq_ff;
   nca_tag_type             tag1_ff, tag2_ff;
   logic [ACC_W-1:0]        acc_in, acc_ff;
   logic [ACC_W-1:0]        total;
   logic [ACC_W-1:0]        best_sum_in, best_sum_ff;
   logic [CENT_W-1:0]       best_in, best_ff;
   logic                    take;
   nca_result_type          result_in, result_ff;

   // stage 1: |p - c|
   always_comb begin
      diff   = (COORD_W+1)'(pt_coord) - (COORD_W+1)'(ct_coord);
      mag_in = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);
   end

   // stage 2: square
   assign sq_in = SQ_W'(mag_ff) * SQ_W'(mag_ff);

   // stage 3: accumulate, compare at end of each centroid
   always_comb begin
      total        = acc_ff + ACC_W'(sq_ff);
      take         = tag2_ff.first_cent || (total < best_sum_ff);
      acc_in       = acc_ff;
      best_sum_in  = best_sum_ff;
      best_in      = best_ff;
      result_in    = '0;
      result_in.best = best_ff;
      if (tag2_ff.valid) begin
         acc_in = tag2_ff.last_dim ? '0 : total;
         if (tag2_ff.last_dim && take) begin
            best_sum_in = total;
            best_in     = tag2_ff.cent;
         end
         if (tag2_ff.last_dim && tag2_ff.last_cent) begin
            result_in.done = 1'b1;
            result_in.best = best_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff   <= '0;
         tag2_ff   <= '0;
         acc_ff    <= '0;
         result_ff <= '0;
      end else begin
         tag1_ff   <= tag;
         tag2_ff   <= tag1_ff;
         acc_ff    <= acc_in;
         result_ff <= result_in;
      end
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      best_sum_ff  <= best_sum_in;
      best_ff      <= best_in;
   end

   assign result = result_ff;

endmodule

// ===== tb/nearest_centroid_assign_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_assign_tb
// Loads centroid and point coordinates, then queries stored points and checks
// each returned centroid index against an exact squared-distance predictor.
// Register settings run from the reset values through both extremes, and the
// handshakes on both sides see random gaps, a long result stall and drains.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_tb;
   import nca_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_CYCLES    = 1000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUERY_LAT_MAX = MAX_CENTROIDS * MAX_DIMS + 8;
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic [ENTRY_W-1:0]        entry;
      logic [DIMIN_W-1:0]        dim;
      logic signed [COORD_W-1:0] coord;
   } req_item_type;

   logic clock;
   logic reset;

   nca_req_if req_if ();
   nca_rsp_if rsp_if ();
   nca_csr_if csr_if ();

   nearest_centroid_assign dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // predictor state
   logic signed [COORD_W-1:0] centroid_mem [MAX_CENTROIDS*MAX_DIMS];
   logic signed [COORD_W-1:0] point_mem [MAX_POINTS*MAX_DIMS];
   logic [CFG_W-1:0]          centroid_cfg = 1;
   logic [CFG_W-1:0]          dims_cfg = 1;
   logic [BEST_W-1:0]         nearest_q [$];

   // centroid entries written so far, so no query reads an unwritten one
   bit centroid_ok [MAX_CENTROIDS*MAX_DIMS];

   req_item_type req_q [$];
   req_item_type next_req;
   bit        req_taken;
   int        req_gap_left;
   int        rsp_gap_left;
   int        rsp_hold_left;
   bit        hold_go;
   bit        idle_enabled;
   bit        no_idle;
   bit        coarse_coords;

   int err_count;
   int cycle_count;
   int items_accepted;
   int queries_accepted;
   int results_checked;
   int reg_writes;
   logic [BEST_W-1:0] want_best;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.op          = '0;
      req_if.entry_index = '0;
      req_if.dim_index   = '0;
      req_if.coord_value = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   function automatic int clamp_count(input logic [CFG_W-1:0] raw, input int top);
      int v;
      v = int'(raw);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic logic [BEST_W-1:0] nearest_centroid(input int pt);
      int nc, nd, c, d;
      longint diff;
      logic [ACC_W-1:0] sum_cur, sum_best;
      logic [BEST_W-1:0] best;
      nc = clamp_count(centroid_cfg, MAX_CENTROIDS);
      nd = clamp_count(dims_cfg, MAX_DIMS);
      best = '0;
      sum_best = '0;
      for (c = 0; c < nc; c++) begin
         sum_cur = '0;
         for (d = 0; d < nd; d++) begin
            diff = longint'(point_mem[pt*MAX_DIMS + d])
                 - longint'(centroid_mem[c*MAX_DIMS + d]);
            sum_cur += ACC_W'(diff * diff);
         end
         // strict compare keeps the lower index on a tie
         if (c == 0 || sum_cur < sum_best) begin
            sum_best = sum_cur;
            best = BEST_W'(c);
         end
      end
      return best;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      err_count++;
   endtask

   // ---------------- monitor and predictor update ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (nearest_q.size() == 0) begin
               report_mismatch($sformatf("result %0d with no query pending",
                                         rsp_if.best_centroid));
            end else begin
               want_best = nearest_q.pop_front();
               results_checked++;
               if (rsp_if.best_centroid !== want_best)
                  report_mismatch($sformatf("best_centroid got %0d, want %0d",
                                            rsp_if.best_centroid, want_best));
            end
         end
         req_taken = (req_if.valid === 1'b1 && req_if.ready === 1'b1);
         if (req_taken) begin
            items_accepted++;
            case (req_if.op)
               OP_LOAD_CENT: begin
                  if (req_if.entry_index < MAX_CENTROIDS && req_if.dim_index < MAX_DIMS)
                     centroid_mem[req_if.entry_index*MAX_DIMS + req_if.dim_index] =
                        req_if.coord_value;
               end
               OP_LOAD_POINT: begin
                  if (req_if.entry_index < MAX_POINTS && req_if.dim_index < MAX_DIMS)
                     point_mem[req_if.entry_index*MAX_DIMS + req_if.dim_index] =
                        req_if.coord_value;
               end
               OP_QUERY: begin
                  if (req_if.entry_index < MAX_POINTS) begin
                     queries_accepted++;
                     nearest_q.insert(nearest_q.size(),
                                      nearest_centroid(req_if.entry_index));
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // hold the item until it is taken
      end else if (req_gap_left > 0) begin
         req_gap_left--;
         req_if.valid <= 1'b0;
      end else if (idle_enabled && !no_idle && $urandom_range(0, 99) < 15) begin
         req_gap_left = $urandom_range(1, 8) - 1;
         req_if.valid <= 1'b0;
      end else if (req_q.size() > 0) begin
         next_req = req_q.pop_front();
         req_if.valid       <= 1'b1;
         req_if.op          <= next_req.op;
         req_if.entry_index <= next_req.entry;
         req_if.dim_index   <= next_req.dim;
         req_if.coord_value <= next_req.coord;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // ---------------- result receiver ----------------
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
      end else if (hold_go) begin
         rsp_hold_left = HOLD_CYCLES;
         hold_go = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold_left > 0 || hold_go) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_enabled && !no_idle && $urandom_range(0, 99) < 20) begin
         rsp_gap_left = $urandom_range(1, 8) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, nearest_q.size());
         $display("nearest_centroid_assign_tb: done, errors");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic signed [COORD_W-1:0] rand_coord();
      int r;
      int v;
      r = $urandom_range(0, 15);
      if (r == 0) return 16'sh8000;
      if (r == 1) return 16'sh7fff;
      if (coarse_coords) begin
         v = $urandom_range(0, 4);
         return COORD_W'((v - 2) * 128);
      end
      return COORD_W'($urandom);
   endfunction

   task automatic push_item(input logic [OP_W-1:0] op, input int entry, input int dim,
                            input logic signed [COORD_W-1:0] v);
      req_item_type it;
      it.op    = op;
      it.entry = ENTRY_W'(entry);
      it.dim   = DIMIN_W'(dim);
      it.coord = v;
      req_q.insert(req_q.size(), it);
   endtask

   task automatic load_centroid(input int c, input int d, input logic signed [COORD_W-1:0] v);
      push_item(OP_LOAD_CENT, c, d, v);
      if (c < MAX_CENTROIDS) centroid_ok[c*MAX_DIMS + d] = 1'b1;
   endtask

   task automatic load_point(input int p, input int d, input logic signed [COORD_W-1:0] v);
      push_item(OP_LOAD_POINT, p, d, v);
   endtask

   task automatic wait_results_drained();
      while (req_q.size() != 0 || req_if.valid || nearest_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic settle_block();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= CFG_W'(val);
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      if (idx == CSR_CENTROIDS) centroid_cfg = CFG_W'(val);
      else dims_cfg = CFG_W'(val);
      reg_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // one register setting: fill what the query range needs, then mixed traffic
   task automatic run_phase(input int craw, input int draw, input int npts,
                            input int nacts, input bit use_hold);
      int nc, nd, c, d, k, p, roll;
      int pts [$];
      settle_block();
      write_reg(CSR_CENTROIDS, craw);
      write_reg(CSR_DIMS, draw);
      idle_enabled  = no_idle ? 1'b0 : ($urandom_range(0, 3) != 0);
      coarse_coords = $urandom_range(0, 1);
      nc = clamp_count(CFG_W'(craw), MAX_CENTROIDS);
      nd = clamp_count(CFG_W'(draw), MAX_DIMS);
      if (use_hold) begin
         @(negedge clock);
         hold_go = 1'b1;
      end
      for (c = 0; c < nc; c++)
         for (d = 0; d < nd; d++)
            if (!centroid_ok[c*MAX_DIMS + d] || $urandom_range(0, 5) == 0)
               load_centroid(c, d, rand_coord());
      for (k = 0; k < npts; k++) begin
         p = (k == 0 && $urandom_range(0, 1)) ? MAX_POINTS - 1
                                              : $urandom_range(0, MAX_POINTS - 1);
         pts.insert(pts.size(), p);
         for (d = 0; d < nd; d++) load_point(p, d, rand_coord());
      end
      for (k = 0; k < nacts; k++) begin
         // sender stops here until every answer is back
         if (k == nacts / 2) wait_results_drained();
         // during a result stall, queries pile up so the input backs up
         roll = (use_hold && k < nacts / 2) ? 0 : $urandom_range(0, 19);
         if (roll <= 10) begin
            push_item(OP_QUERY, pts[$urandom_range(0, pts.size() - 1)], 0, rand_coord());
         end else if (roll <= 13) begin
            load_point(pts[$urandom_range(0, pts.size() - 1)], $urandom_range(0, nd - 1),
                       rand_coord());
         end else if (roll <= 15) begin
            load_centroid($urandom_range(0, nc - 1), $urandom_range(0, nd - 1), rand_coord());
         end else if (roll == 16) begin
            push_item(OP_UNUSED, $urandom, $urandom, COORD_W'($urandom));
         end else if (roll == 17) begin
            push_item(OP_LOAD_CENT, $urandom_range(MAX_CENTROIDS, 255),
                      $urandom_range(0, MAX_DIMS - 1), rand_coord());
         end else begin
            load_centroid($urandom_range(0, MAX_CENTROIDS - 1),
                          $urandom_range(0, MAX_DIMS - 1), rand_coord());
         end
      end
   endtask

   initial begin
      int k;
      @(negedge clock);
      while (reset) @(negedge clock);

      // reset counts: one centroid, one dimension, extreme values
      idle_enabled = 1'b1;
      load_centroid(0, 0, 16'sh8000);
      load_point(0, 0, 16'sh7fff);
      push_item(OP_QUERY, 0, 0, 0);
      push_item(OP_LOAD_CENT, MAX_CENTROIDS, 0, 1234);
      push_item(OP_LOAD_CENT, 255, 63, -1);
      push_item(OP_UNUSED, 255, 63, -1);
      load_point(MAX_POINTS - 1, MAX_DIMS - 1, 16'sh7fff);
      push_item(OP_UNUSED, 0, 0, 0);

      // three centroids on a circle around the origin: exact ties
      settle_block();
      write_reg(CSR_CENTROIDS, 3);
      write_reg(CSR_DIMS, 2);
      load_centroid(0, 0, 256);
      load_centroid(0, 1, 0);
      load_centroid(1, 0, 0);
      load_centroid(1, 1, 256);
      load_centroid(2, 0, -256);
      load_centroid(2, 1, 0);
      load_point(1, 0, 0);
      load_point(1, 1, 0);
      load_point(2, 0, -128);
      load_point(2, 1, 128);
      load_point(3, 0, 16'sh8000);
      load_point(3, 1, 16'sh8000);
      load_point(MAX_POINTS - 1, 0, 16'sh7fff);
      load_point(MAX_POINTS - 1, 1, 16'sh7fff);
      push_item(OP_QUERY, 1, 0, 0);
      push_item(OP_QUERY, 2, 0, 0);
      push_item(OP_QUERY, 3, 0, 0);
      push_item(OP_QUERY, MAX_POINTS - 1, 0, 0);

      run_phase(127, 0, 2, 8, 1'b0);
      for (k = 0; k < 2; k++)
         run_phase($urandom_range(1, 4), $urandom_range(1, 3), 2, 8, k == 0);
      no_idle = 1'b1;
      run_phase(3, 3, 2, 12, 1'b0);

      wait_results_drained();
      repeat (QUERY_LAT_MAX) @(posedge clock);
      if (nearest_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", nearest_q.size()));
      $display("covered: %0d items (%0d queries), %0d results checked, %0d register writes",
               items_accepted, queries_accepted, results_checked, reg_writes);
      $display("all 64 centroids, out-of-range counts, ties, ignored ops, %0d errors",
               err_count);
      if (err_count == 0)
         $display("nearest_centroid_assign_tb: done, clean");
      else
         $display("nearest_centroid_assign_tb: done, errors");
      $finish;
   end

endmodule

// ===== nearest_centroid_assign.f =====
rtl/nca_pkg.sv
rtl/nca_if.sv
rtl/nca_ram.sv
rtl/nca_dist_unit.sv
rtl/nearest_centroid_assign.sv
tb/nearest_centroid_assign_tb.sv
